### src/bsmg_pkg.sv
`default_nettype none

package bsmg_pkg;

    localparam int DATA_W              = 32;
    localparam int CAP_W               = 11;
    localparam int PADDR_W             = 3;
    localparam int MAX_ENTRIES_DEFAULT = 1024;

    localparam logic [CAP_W-1:0]   CAPACITY_RESET = 11'd1024;
    localparam logic [PADDR_W-1:0] ADDR_CAPACITY  = 3'd0;

    // shared subtract unit result
    typedef struct packed {
        logic [DATA_W-1:0] diff;  // a - b modulo 2^32
        logic              lt;    // a < b, signed
    } alu_res_t;

endpackage

`default_nettype wire

### src/bsmg_ram.sv
`default_nettype none

module bsmg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### src/bsmg_alu.sv
`default_nettype none

module bsmg_alu (
    input  wire logic [bsmg_pkg::DATA_W-1:0] a,
    input  wire logic [bsmg_pkg::DATA_W-1:0] b,
    output bsmg_pkg::alu_res_t               res
);

    import bsmg_pkg::*;

    logic [DATA_W:0] wide;

    // sign-extended subtract: top bit is the signed less-than
    assign wide     = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    assign res.diff = wide[DATA_W-1:0];
    assign res.lt   = wide[DATA_W];

endmodule

`default_nettype wire

### src/bounded_set_min_gap_and_range_core.sv
`default_nettype none

// Bounded set tracker: keeps up to min(capacity, MAX_ENTRIES) signed 32-bit
// values in an ascending sorted RAM and reports, per input transfer, one result
// transfer with the accept flag, the held count and (once two or more values
// are held) the smallest neighbour gap and the max-minus-min range. An insert
// walks the RAM from the top entry down, moving each larger entry up one slot,
// one entry per cycle through the single RAM port pair, then writes the new
// value and updates the gaps and the range; a rejected item skips the walk
// and the write. A finished item waits for the previous result to be taken.
// The block takes one item at a time; value_ready is high only while idle.
// A finished result sits in the output register until taken, and the next
// item may already be accepted.
// Capacity is written at byte address 0 of the APB port; the user writes it only
// while idle, which the block itself does not enforce. Equal values are stored
// after the existing equal ones; duplicates make the shortest span zero.

module bounded_set_min_gap_and_range_core #(
    parameter int MAX_ENTRIES = bsmg_pkg::MAX_ENTRIES_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // input channel
    input  wire logic                         value_valid,
    output logic                              value_ready,
    input  wire logic [bsmg_pkg::DATA_W-1:0]  value,
    // result channel
    output logic                              result_valid,
    input  wire logic                         result_ready,
    output logic                              accepted,
    output logic      [bsmg_pkg::CAP_W-1:0]   count,
    output logic                              has_span,
    output logic      [bsmg_pkg::DATA_W-1:0]  shortest_span,
    output logic      [bsmg_pkg::DATA_W-1:0]  longest_span,
    // APB config
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bsmg_pkg::PADDR_W-1:0] paddr,
    input  wire logic [bsmg_pkg::DATA_W-1:0]  pwdata,
    output logic      [bsmg_pkg::DATA_W-1:0]  prdata,
    output logic                              pready
);

    import bsmg_pkg::*;

    localparam int AW    = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_GAP_HI,
        ST_SPAN,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CAP_W-1:0]  capacity_reg;
    logic [CNT_W-1:0]  held_count_reg, held_count_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic [DATA_W-1:0] least_reg, least_next;
    logic [DATA_W-1:0] greatest_reg, greatest_next;
    logic [DATA_W-1:0] gap_reg, gap_next;
    logic [DATA_W-1:0] below_reg, below_next;
    logic [DATA_W-1:0] above_reg, above_next;
    logic [DATA_W-1:0] span_reg, span_next;
    logic              have_below_reg, have_below_next;
    logic              have_above_reg, have_above_next;
    logic              acc_reg, acc_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_acc_reg, out_acc_next;
    logic [CAP_W-1:0]  out_count_reg, out_count_next;
    logic              out_has_reg, out_has_next;
    logic [DATA_W-1:0] out_short_reg, out_short_next;
    logic [DATA_W-1:0] out_long_reg, out_long_next;

    // RAM and shared unit hookup
    logic              ram_wr_en, ram_rd_en;
    logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
    logic [DATA_W-1:0] ram_wr_data, ram_rd_data;
    logic [DATA_W-1:0] alu_a, alu_b;
    alu_res_t          alu_res;

    logic              in_xfer;
    logic              room;
    logic [LIM_W-1:0]  held_ext, cap_ext, max_ext, limit;
    logic [CNT_W-1:0]  held_m1;
    logic              cfg_write;

    bsmg_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    bsmg_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    // ---------------------------------------------------------------
    // APB: single capacity register, always ready
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr == ADDR_CAPACITY) ? DATA_W'(capacity_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (cfg_write && paddr == ADDR_CAPACITY)
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // effective capacity = min(capacity, MAX_ENTRIES)
    // ---------------------------------------------------------------
    assign held_ext = LIM_W'(held_count_reg);
    assign cap_ext  = LIM_W'(capacity_reg);
    assign max_ext  = LIM_W'(MAX_ENTRIES);
    assign limit    = (cap_ext < max_ext) ? cap_ext : max_ext;
    assign room     = held_ext < limit;
    assign held_m1  = held_count_reg - CNT_W'(1);

    assign value_ready = (state_reg == ST_IDLE);
    assign in_xfer     = value_valid && value_ready;

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        held_count_next = held_count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        value_next      = value_reg;
        least_next      = least_reg;
        greatest_next   = greatest_reg;
        gap_next        = gap_reg;
        below_next      = below_reg;
        above_next      = above_reg;
        span_next       = span_reg;
        have_below_next = have_below_reg;
        have_above_next = have_above_reg;
        acc_next        = acc_reg;

        out_valid_next  = out_valid_reg && !result_ready;
        out_acc_next    = out_acc_reg;
        out_count_next  = out_count_reg;
        out_has_next    = out_has_reg;
        out_short_next  = out_short_reg;
        out_long_next   = out_long_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = pos_reg;
        ram_wr_data = value_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = idx_reg;

        alu_a = value_reg;
        alu_b = ram_rd_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    value_next      = value;
                    have_below_next = 1'b0;
                    have_above_next = 1'b0;
                    acc_next        = room;
                    if (!room)
                    begin
                        state_next = ST_SPAN;
                    end
                    else if (held_count_reg == '0)
                    begin
                        pos_next   = '0;
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        // start at the top entry
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = held_m1[AW-1:0];
                        idx_next    = held_m1[AW-1:0];
                        state_next  = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // rd_data holds entry idx; new value goes above it unless smaller
                alu_a = value_reg;
                alu_b = ram_rd_data;
                if (alu_res.lt)
                begin
                    ram_wr_en       = 1'b1;
                    ram_wr_addr     = idx_reg + AW'(1);
                    ram_wr_data     = ram_rd_data;
                    above_next      = ram_rd_data;
                    have_above_next = 1'b1;
                    if (idx_reg == '0)
                    begin
                        pos_next   = '0;
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = idx_reg - AW'(1);
                        idx_next    = idx_reg - AW'(1);
                    end
                end
                else
                begin
                    below_next      = ram_rd_data;
                    have_below_next = 1'b1;
                    pos_next        = idx_reg + AW'(1);
                    state_next      = ST_PLACE;
                end
            end

            ST_PLACE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = pos_reg;
                ram_wr_data = value_reg;
                // gap to lower neighbour
                alu_a = value_reg;
                alu_b = below_reg;
                if (have_below_reg && alu_res.diff < gap_reg)
                begin
                    gap_next = alu_res.diff;
                end
                if (held_count_reg == '0)
                begin
                    least_next    = value_reg;
                    greatest_next = value_reg;
                end
                else
                begin
                    if ($signed(value_reg) < $signed(least_reg))
                    begin
                        least_next = value_reg;
                    end
                    if ($signed(greatest_reg) < $signed(value_reg))
                    begin
                        greatest_next = value_reg;
                    end
                end
                held_count_next = held_count_reg + CNT_W'(1);
                state_next      = have_above_reg ? ST_GAP_HI : ST_SPAN;
            end

            ST_GAP_HI:
            begin
                // gap to upper neighbour
                alu_a = above_reg;
                alu_b = value_reg;
                if (alu_res.diff < gap_reg)
                begin
                    gap_next = alu_res.diff;
                end
                state_next = ST_SPAN;
            end

            ST_SPAN:
            begin
                alu_a      = greatest_reg;
                alu_b      = least_reg;
                span_next  = alu_res.diff;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = acc_reg;
                    out_count_next = CAP_W'(held_count_reg);
                    out_has_next   = held_count_reg >= CNT_W'(2);
                    out_short_next = (held_count_reg >= CNT_W'(2)) ? gap_reg : '0;
                    out_long_next  = (held_count_reg >= CNT_W'(2)) ? span_reg : '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            held_count_reg <= '0;
            least_reg      <= '0;
            greatest_reg   <= '0;
            gap_reg        <= '1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_count_reg <= held_count_next;
            least_reg      <= least_next;
            greatest_reg   <= greatest_next;
            gap_reg        <= gap_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload and scratch, no reset needed
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        value_reg      <= value_next;
        below_reg      <= below_next;
        above_reg      <= above_next;
        span_reg       <= span_next;
        have_below_reg <= have_below_next;
        have_above_reg <= have_above_next;
        acc_reg        <= acc_next;
        out_acc_reg    <= out_acc_next;
        out_count_reg  <= out_count_next;
        out_has_reg    <= out_has_next;
        out_short_reg  <= out_short_next;
        out_long_reg   <= out_long_next;
    end

    assign result_valid  = out_valid_reg;
    assign accepted      = out_acc_reg;
    assign count         = out_count_reg;
    assign has_span      = out_has_reg;
    assign shortest_span = out_short_reg;
    assign longest_span  = out_long_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (held_count_reg == $past(held_count_reg)) ||
                 (held_count_reg == $past(held_count_reg) + CNT_W'(1)))
        else $error("held count moved by more than one");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (CNT_W'(idx_reg) < held_count_reg))
        else $error("scan index beyond held entries");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !value_ready)
        else $error("input taken while an item is in progress");

    a_acc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && accepted) |-> (count != '0))
        else $error("accepted result with zero count");

endmodule

`default_nettype wire
